@@ hw/rtl/rdsf_pkg.sv @@
`default_nettype none

package rdsf_pkg;

   // Field widths
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int DCOUNT_W   = 5;
   localparam int ALPHA_W    = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Alphabet layout: 16 byte-wide symbol slots over two 64-bit words
   localparam int NUM_SLOTS     = 16;
   localparam int SLOTS_PER_W   = ALPHA_W / CHAR_W;
   localparam int SYM_W         = $clog2(NUM_SLOTS);
   localparam int MAX_SYMBOLS   = 16;

   // Conversion: 8 quotient bits per cycle
   localparam int DIV_BITS   = 8;
   localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam int NDIG_W     = $clog2(VALUE_W + 1);

   // Register indexes (address bits above the 8-byte word offset)
   localparam int REG_IDX_W = CSR_ADDR_W - 3;
   localparam logic [REG_IDX_W-1:0] REG_DIGIT_COUNT   = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_ALPHABET_LOW  = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_ALPHABET_HIGH = REG_IDX_W'(2);

   // Register reset values: "0123456789"
   localparam logic [DCOUNT_W-1:0] DIGIT_COUNT_RST   = DCOUNT_W'(10);
   localparam logic [ALPHA_W-1:0]  ALPHABET_LOW_RST  = 64'h3736_3534_3332_3130;
   localparam logic [ALPHA_W-1:0]  ALPHABET_HIGH_RST = 64'h0000_0000_0000_3938;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [DCOUNT_W-1:0] digit_count;
      logic [ALPHA_W-1:0]  alphabet_low;
      logic [ALPHA_W-1:0]  alphabet_high;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      logic emit_sign;
      logic emit_digit;
      logic emit_error;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic alpha_ok;
      logic negative;
      logic digit_final;
      logic last_digit;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/rdsf_req_if.sv @@
`default_nettype none

interface rdsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rdsf_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rdsf_rsp_if.sv @@
`default_nettype none

interface rdsf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rdsf_pkg::CHAR_W-1:0]    character;
   logic                           last;
   logic                           bad_alphabet;

   modport source (output valid, output character, output last, output bad_alphabet,
                   input ready);
   modport sink   (input valid, input character, input last, input bad_alphabet,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/radix_digit_string_formatter.sv @@
`default_nettype none

// Formats a signed 32-bit value as text in a radix set by the alphabet registers, one
// character per response transaction, sign first, most significant digit first, with
// last marking the final character. An alphabet that is too short, holds '+', '-' or a
// space, or repeats a symbol yields a single response with bad_alphabet set. A shared
// divider produces 8 quotient bits a cycle, digit after digit, and the characters then
// leave at one per cycle while the response side does not stall. A new request is taken
// once the last character sits in the output register. Write the registers only while
// no request is in flight.
module radix_digit_string_formatter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rdsf_req_if.sink                             req_if,
   rdsf_rsp_if.source                           rsp_if,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rdsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rdsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rdsf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import rdsf_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   rdsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rdsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdsf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_value        (req_if.value),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_character    (rsp_if.character),
      .rsp_last         (rsp_if.last),
      .rsp_bad_alphabet (rsp_if.bad_alphabet),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

@@ hw/rtl/rdsf_csr.sv @@
`default_nettype none

module rdsf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rdsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rdsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rdsf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output rdsf_pkg::cfg_type                    cfg
);
   import rdsf_pkg::*;

   logic [DCOUNT_W-1:0]  digit_count_ff;
   logic [ALPHA_W-1:0]   alphabet_low_ff;
   logic [ALPHA_W-1:0]   alphabet_high_ff;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Write registers in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff   <= DIGIT_COUNT_RST;
         alphabet_low_ff  <= ALPHABET_LOW_RST;
         alphabet_high_ff <= ALPHABET_HIGH_RST;
      end else if (wr_en) begin
         case (idx)
            REG_DIGIT_COUNT:   digit_count_ff   <= csr_pwdata[DCOUNT_W-1:0];
            REG_ALPHABET_LOW:  alphabet_low_ff  <= csr_pwdata[ALPHA_W-1:0];
            REG_ALPHABET_HIGH: alphabet_high_ff <= csr_pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_DIGIT_COUNT:   csr_prdata = CSR_DATA_W'(digit_count_ff);
         REG_ALPHABET_LOW:  csr_prdata = CSR_DATA_W'(alphabet_low_ff);
         REG_ALPHABET_HIGH: csr_prdata = CSR_DATA_W'(alphabet_high_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.digit_count   = digit_count_ff;
   assign cfg.alphabet_low  = alphabet_low_ff;
   assign cfg.alphabet_high = alphabet_high_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rdsf_ctrl.sv @@
`default_nettype none

module rdsf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire rdsf_pkg::dp_status_type status,
   output rdsf_pkg::dp_cmd_type         cmd
);
   import rdsf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SIGN,
      ST_DIGITS,
      ST_ERROR
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 cnt_last;

   assign cnt_last  = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.alpha_ok ? ST_DIV : ST_ERROR;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_last) begin
               cmd.div_last = 1'b1;
               cnt_in       = '0;
               if (status.digit_final) begin
                  state_in = status.negative ? ST_SIGN : ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            if (status.out_free) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rdsf_dp.sv @@
`default_nettype none

module rdsf_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rdsf_pkg::cfg_type                   cfg,
   input  wire logic signed [rdsf_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic             [rdsf_pkg::CHAR_W-1:0]  rsp_character,
   output logic                                     rsp_last,
   output logic                                     rsp_bad_alphabet,
   input  wire rdsf_pkg::dp_cmd_type                cmd,
   output rdsf_pkg::dp_status_type                  status
);
   import rdsf_pkg::*;

   logic [CHAR_W-1:0]   sym [NUM_SLOTS];
   logic [DCOUNT_W-1:0] cap;
   logic [DCOUNT_W-1:0] alen;
   logic                aok;

   logic [DCOUNT_W-1:0] radix_ff;
   logic                alpha_ok_ff;
   logic                neg_ff;
   logic [VALUE_W-1:0]  mag_ff;
   logic [SYM_W-1:0]    rem_ff;
   logic [SYM_W-1:0]    stack_ff [VALUE_W];
   logic [NDIG_W-1:0]   ndig_ff;

   logic [VALUE_W-1:0]  q_next;
   logic [SYM_W-1:0]    r_next;

   logic                out_valid_ff;
   logic [CHAR_W-1:0]   out_char_ff;
   logic                out_last_ff;
   logic                out_bad_ff;

   // Split the alphabet words into symbol slots
   always_comb begin
      for (int i = 0; i < SLOTS_PER_W; i++) begin
         sym[i]               = cfg.alphabet_low[i*CHAR_W +: CHAR_W];
         sym[i + SLOTS_PER_W] = cfg.alphabet_high[i*CHAR_W +: CHAR_W];
      end
   end

   // Alphabet length: digit count capped, then cut at the first zero byte
   always_comb begin
      cap  = (cfg.digit_count > DCOUNT_W'(MAX_SYMBOLS)) ? DCOUNT_W'(MAX_SYMBOLS)
                                                        : cfg.digit_count;
      alen = cap;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (sym[i] == CHAR_NUL && DCOUNT_W'(i) < cap) begin
            alen = DCOUNT_W'(i);
         end
      end
   end

   // Validity: two or more symbols, no sign or space, no repeats
   always_comb begin
      aok = (alen >= DCOUNT_W'(2));
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (DCOUNT_W'(i) < alen) begin
            if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS || sym[i] == CHAR_SPACE) begin
               aok = 1'b0;
            end
            for (int j = i + 1; j < NUM_SLOTS; j++) begin
               if (DCOUNT_W'(j) < alen && sym[j] == sym[i]) begin
                  aok = 1'b0;
               end
            end
         end
      end
   end

   // Restoring division by the radix, DIV_BITS quotient bits per cycle
   always_comb begin
      logic [SYM_W:0]     r;
      logic [VALUE_W-1:0] q;
      r = {1'b0, rem_ff};
      q = mag_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r = {r[SYM_W-1:0], q[VALUE_W-1]};
         q = {q[VALUE_W-2:0], 1'b0};
         if (r >= radix_ff) begin
            r    = r - radix_ff;
            q[0] = 1'b1;
         end
      end
      q_next = q;
      r_next = r[SYM_W-1:0];
   end

   // Load the transaction, then run the conversion
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radix_ff    <= alen;
         alpha_ok_ff <= aok;
         neg_ff      <= req_value[VALUE_W-1];
         mag_ff      <= req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                             : VALUE_W'(req_value);
         rem_ff      <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= q_next;
         rem_ff <= cmd.div_last ? '0 : r_next;
      end
   end

   // Digit stack: push at the top, most significant digit ends on top
   always_ff @(posedge clock) begin
      if (cmd.div_step && cmd.div_last) begin
         stack_ff[0] <= r_next;
         for (int i = 1; i < VALUE_W; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (cmd.emit_digit) begin
         for (int i = 0; i < VALUE_W - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   // Digit count
   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff <= '0;
      end else if (cmd.load) begin
         ndig_ff <= '0;
      end else if (cmd.div_step && cmd.div_last) begin
         ndig_ff <= ndig_ff + NDIG_W'(1);
      end else if (cmd.emit_digit) begin
         ndig_ff <= ndig_ff - NDIG_W'(1);
      end
   end

   // Output register: hold until taken, reload when free
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_error) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         out_char_ff <= CHAR_MINUS;
         out_last_ff <= 1'b0;
         out_bad_ff  <= 1'b0;
      end else if (cmd.emit_digit) begin
         out_char_ff <= sym[stack_ff[0]];
         out_last_ff <= (ndig_ff == NDIG_W'(1));
         out_bad_ff  <= 1'b0;
      end else if (cmd.emit_error) begin
         out_char_ff <= CHAR_NUL;
         out_last_ff <= 1'b1;
         out_bad_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_character    = out_char_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_bad_alphabet = out_bad_ff;

   assign status.alpha_ok    = alpha_ok_ff;
   assign status.negative    = neg_ff;
   assign status.digit_final = (q_next == '0) || (ndig_ff == NDIG_W'(VALUE_W - 1));
   assign status.last_digit  = (ndig_ff == NDIG_W'(1));
   assign status.out_free    = ~out_valid_ff | rsp_ready;

endmodule

`default_nettype wire
